FILE: hw/rtl/fpa_pkg.sv
// shared widths, register indexes and policy codes for the fit-policy allocator
package fpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int REQ_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

endpackage

FILE: hw/rtl/fit_policy_partition_allocator_core.sv
// Fit-policy allocator: a table of free block sizes in a memory with one read
// and one write port, scanned one entry per cycle by one comparator for first,
// best or worst fit (the unused mode code acts as first fit). A load word writes
// one entry and the block stays ready for the next word. After a request word is
// accepted, in_ready stays low while the block reads each of the first
// min(block_count, 64) table entries, waits for the last registered read to come
// back and be compared, closes the scan, writes back the reduced entry (granted
// only) and posts the result. Reading one entry at a time into a single
// comparator bounds the scan. Input is not taken while a request is being worked
// on; a posted result may wait for out_ready while new words are accepted, and a
// later request is scanned but posts its result only once that result is taken.
module fit_policy_partition_allocator_core
  import fpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [IDX_W-1:0]      block_index,
  input  logic [SIZE_BITS-1:0]  size_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  granted,
  output logic [IDX_W-1:0]      chosen_block,
  output logic [SIZE_BITS-1:0]  size_left,
  output logic [REQ_W-1:0]      request_number,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB,
    S_DONE
  } state_t;

  state_t               state;
  logic [MODE_W-1:0]    fit_mode;
  logic [CNT_W-1:0]     block_count;
  logic [REQ_W-1:0]     request_counter;

  logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data;

  logic [CNT_W-1:0]     issue;
  logic                 pend_v;
  logic [IDX_W-1:0]     pend_idx;
  logic [SIZE_BITS-1:0] req_size;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_val;
  logic [SIZE_BITS-1:0] res_left;

  logic [CNT_W-1:0]     limit;
  logic                 in_fire;
  logic                 fits;
  logic                 take;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SIZE_BITS-1:0] reduced;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign limit    = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;
  assign fits     = (rd_data >= req_size);
  assign reduced  = best_val - req_size;

  // shared compare: decides whether the entry just read replaces the pick
  always_comb begin
    take = 1'b0;
    if (pend_v && fits) begin
      if (!found) begin
        take = 1'b1;
      end else begin
        case (fit_mode)
          MODE_BEST:  take = (rd_data < best_val);
          MODE_WORST: take = (rd_data > best_val);
          default:    take = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = block_index;
    mem_wdata = size_value;
    if (state == S_WB) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx;
      mem_wdata = reduced;
    end else if (in_fire && kind == KIND_LOAD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[issue[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      fit_mode        <= MODE_FIRST;
      block_count     <= '0;
      request_counter <= '0;
      out_valid       <= 1'b0;
      pend_v          <= 1'b0;
      found           <= 1'b0;
      issue           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_MODE:    fit_mode    <= cfg_data[MODE_W-1:0];
          CFG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
          default:         ;
        endcase
      end

      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && kind == KIND_REQUEST) begin
            req_size <= size_value;
            issue    <= '0;
            pend_v   <= 1'b0;
            found    <= 1'b0;
            best_idx <= '0;
            best_val <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read address issue; data comes back in the following cycle
          if (issue < limit) begin
            pend_v   <= 1'b1;
            pend_idx <= issue[IDX_W-1:0];
            issue    <= issue + CNT_W'(1);
          end else begin
            pend_v <= 1'b0;
          end
          if (take) begin
            found    <= 1'b1;
            best_idx <= pend_idx;
            best_val <= rd_data;
          end
          if (issue >= limit && !pend_v) begin
            state <= found ? S_WB : S_DONE;
          end
        end
        S_WB: begin
          res_left <= reduced;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            granted         <= found;
            chosen_block    <= found ? best_idx : '0;
            size_left       <= found ? res_left : '0;
            request_number  <= request_counter;
            request_counter <= request_counter + REQ_W'(1);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/fpa_checker.sv
// port-level checks for the fit-policy allocator, bound into the allocator core
module fpa_checker
  import fpa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 kind,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 granted,
  input logic [IDX_W-1:0]     chosen_block,
  input logic [SIZE_BITS-1:0] size_left,
  input logic [REQ_W-1:0]     request_number
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(chosen_block)
      && $stable(size_left) && $stable(request_number))
    else $error("result word changed while stalled");

  // a refused request reports zero block and size
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> chosen_block == '0 && size_left == '0)
    else $error("refused request carries nonzero fields");

  // a request occupies the block for the scan
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_REQUEST |=> !in_ready)
    else $error("input taken during a scan");

  // a load leaves the input ready for the next word
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_LOAD |=> in_ready)
    else $error("load word stalled the input");

endmodule

bind fit_policy_partition_allocator_core fpa_checker u_fpa_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .kind           (kind),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .granted        (granted),
  .chosen_block   (chosen_block),
  .size_left      (size_left),
  .request_number (request_number)
);

FILE: test/tb_fit_policy_partition_allocator_core.sv
// testbench for the fit-policy allocator core: predicts each grant and checks every result word
module tb_fit_policy_partition_allocator_core
  import fpa_pkg::*;
;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 1000000;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 95;
  localparam logic [MODE_W-1:0] PHASE_MODE [PHASES] = '{
    MODE_FIRST, MODE_BEST, MODE_WORST, MODE_UNUSED, MODE_BEST, MODE_WORST,
    MODE_FIRST, MODE_UNUSED, MODE_WORST, MODE_BEST, MODE_FIRST, MODE_BEST};
  localparam logic [CFG_DATA_W-1:0] PHASE_COUNT [PHASES] = '{
    7'd64, 7'd64, 7'd5, 7'd127, 7'd1, 7'd0, 7'd33, 7'd65, 7'd64, 7'd2, 7'd16, 7'd100};

  typedef struct {
    logic                 granted;
    logic [IDX_W-1:0]     chosen;
    logic [SIZE_BITS-1:0] left;
    logic [REQ_W-1:0]     number;
  } grant_t;

  class fit_tracker;
    logic [SIZE_BITS-1:0]  free_size [MAX_BLOCKS];
    logic [REQ_W-1:0]      req_count;
    logic [MODE_W-1:0]     fit_mode;
    logic [CFG_DATA_W-1:0] block_count;
    grant_t                expected_grants [$];
    int                    mismatches;

    function new();
      foreach (free_size[j]) free_size[j] = '0;
      req_count   = '0;
      fit_mode    = MODE_FIRST;
      block_count = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FIT_MODE) fit_mode = data[MODE_W-1:0];
      else block_count = data;
    endfunction

    function int scan_span();
      return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function void note_word(logic k, logic [IDX_W-1:0] idx, logic [SIZE_BITS-1:0] sz);
      grant_t g;
      bit     found;
      int     pick;
      if (k == KIND_LOAD) begin
        free_size[idx] = sz;
        return;
      end
      found = 1'b0;
      pick  = 0;
      for (int j = 0; j < scan_span(); j++) begin
        if (free_size[j] < sz) continue;
        if (!found) begin
          found = 1'b1;
          pick  = j;
          if (fit_mode != MODE_BEST && fit_mode != MODE_WORST) break;
        end else if (fit_mode == MODE_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (fit_mode == MODE_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
      g.granted = found;
      g.chosen  = '0;
      g.left    = '0;
      if (found) begin
        free_size[pick] = free_size[pick] - sz;
        g.chosen = IDX_W'(pick);
        g.left   = free_size[pick];
      end
      g.number  = req_count;
      req_count = req_count + 1'b1;
      expected_grants.push_back(g);
    endfunction

    function void check_result(logic g, logic [IDX_W-1:0] c, logic [SIZE_BITS-1:0] l,
                               logic [REQ_W-1:0] n);
      grant_t want;
      if (expected_grants.size() == 0) begin
        if (mismatches < 10)
          $display("result word with nothing pending: granted=%0d block=%0d left=%0d req=%0d",
                   g, c, l, n);
        mismatches++;
        return;
      end
      want = expected_grants.pop_front();
      if (want.granted !== g || want.chosen !== c || want.left !== l || want.number !== n) begin
        if (mismatches < 10)
          $display("mismatch: expected granted=%0d block=%0d left=%0d req=%0d, got %0d %0d %0d %0d",
                   want.granted, want.chosen, want.left, want.number, g, c, l, n);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = KIND_LOAD;
  logic [IDX_W-1:0]      block_index = '0;
  logic [SIZE_BITS-1:0]  size_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  granted;
  logic [IDX_W-1:0]      chosen_block;
  logic [SIZE_BITS-1:0]  size_left;
  logic [REQ_W-1:0]      request_number;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fit_tracker  board = new;
  bit          loaded [MAX_BLOCKS];
  int          burst_left = 0;
  int          stall_left = 0;
  logic [10:0] ready_epoch = '0;
  int unsigned cycle_count = 0;

  fit_policy_partition_allocator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .block_index(block_index), .size_value(size_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted(granted), .chosen_block(chosen_block), .size_left(size_left),
    .request_number(request_number),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // receiver: short random stalls, an occasional long one, and stall-free stretches
  always @(posedge clk) begin
    ready_epoch <= ready_epoch + 1'b1;
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!ready_epoch[9] && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(granted, chosen_block, size_left, request_number);
  end

  task automatic drive_word(input logic k, input logic [IDX_W-1:0] idx,
                            input logic [SIZE_BITS-1:0] sz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    kind        <= k;
    block_index <= idx;
    size_value  <= sz;
    do @(posedge clk); while (!in_ready);
    board.note_word(k, idx, sz);
    if (k == KIND_LOAD) loaded[idx] = 1'b1;
  endtask

  // a request never scans an entry that was not loaded
  task automatic send_word(input logic k, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_BITS-1:0] sz);
    if (k == KIND_REQUEST) begin
      for (int j = 0; j < board.scan_span(); j++)
        if (!loaded[j])
          drive_word(KIND_LOAD, IDX_W'(j), SIZE_BITS'($urandom_range(0, 65534)));
    end
    drive_word(k, idx, sz);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] mode_word,
                             input logic [CFG_DATA_W-1:0] count_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    board.write_reg(CFG_FIT_MODE, mode_word);
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    board.write_reg(CFG_BLOCK_COUNT, count_word);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int                   span;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] sz;
    logic [SIZE_BITS-1:0] pick_v;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty range, tie breaks, exact fit, no fit, unused policy, saturated count
    send_word(KIND_REQUEST, 6'd63, 16'd0);
    settle();
    reconfigure(CFG_DATA_W'(MODE_FIRST), 7'd4);
    send_word(KIND_LOAD, 6'd0, 16'd100);
    send_word(KIND_LOAD, 6'd1, 16'd50);
    send_word(KIND_LOAD, 6'd2, 16'd200);
    send_word(KIND_LOAD, 6'd3, 16'd50);
    send_word(KIND_LOAD, 6'd63, 16'hFFFF);
    send_word(KIND_REQUEST, 6'd0, 16'd60);
    send_word(KIND_REQUEST, 6'd0, 16'hFFFF);
    send_word(KIND_REQUEST, 6'd42, 16'd0);
    settle();
    reconfigure(CFG_DATA_W'(MODE_BEST), 7'd4);
    send_word(KIND_REQUEST, 6'd0, 16'd45);
    send_word(KIND_REQUEST, 6'd0, 16'd5);
    settle();
    reconfigure(CFG_DATA_W'(MODE_WORST), 7'd4);
    send_word(KIND_REQUEST, 6'd0, 16'd10);
    send_word(KIND_LOAD, 6'd3, 16'd190);
    send_word(KIND_REQUEST, 6'd21, 16'd1);
    settle();
    reconfigure({5'h1F, MODE_UNUSED}, 7'd4);
    send_word(KIND_REQUEST, 6'd0, 16'd35);
    settle();
    reconfigure(CFG_DATA_W'(MODE_FIRST), 7'd127);
    send_word(KIND_REQUEST, 6'd0, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      reconfigure({5'($urandom_range(0, 31)), PHASE_MODE[p]}, PHASE_COUNT[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        span = board.scan_span();
        if ($urandom_range(0, 99) < 35) begin
          if (span > 0 && $urandom_range(0, 4) != 0) idx = IDX_W'($urandom_range(0, span - 1));
          else idx = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
          case ($urandom_range(0, 5))
            0:       sz = '0;
            1:       sz = '1;
            2, 3:    sz = SIZE_BITS'($urandom_range(0, 255));
            default: sz = SIZE_BITS'($urandom);
          endcase
          send_word(KIND_LOAD, idx, sz);
        end else begin
          idx    = IDX_W'($urandom);
          pick_v = (span > 0) ? board.free_size[$urandom_range(0, span - 1)] : '0;
          case ($urandom_range(0, 9))
            0:       sz = '0;
            1:       sz = '1;
            2:       sz = SIZE_BITS'($urandom_range(1, 255));
            3, 4:    sz = pick_v;
            5:       sz = (pick_v == '1) ? pick_v : pick_v + 1'b1;
            6, 7:    sz = SIZE_BITS'($urandom_range(0, pick_v));
            default: sz = SIZE_BITS'($urandom);
          endcase
          send_word(KIND_REQUEST, idx, sz);
        end
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
